>>> src/mgha_pkg.sv
`timescale 1ns / 1ps
package mgha_pkg;

   typedef logic [127:0] blk_type;

   typedef enum logic [1:0] {
      FUNC_START  = 2'd0,
      FUNC_ABSORB = 2'd1,
      FUNC_FINISH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_CORR_A,
      OP_CORR_B,
      OP_BLOCK
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CORR_A,
      ST_CORR_B,
      ST_BLOCK
   } state_type;

   typedef enum logic [2:0] {
      REG_H0_HI = 3'd0,
      REG_H0_LO = 3'd1,
      REG_H1_HI = 3'd2,
      REG_H1_LO = 3'd3,
      REG_S0_HI = 3'd4,
      REG_S0_LO = 3'd5,
      REG_S1_HI = 3'd6,
      REG_S1_LO = 3'd7
   } reg_type;

   localparam int unsigned NUM_REGS = 8;
   localparam logic [7:0] REDUCE_BYTE = 8'he1;

   typedef struct packed {
      op_type load;
      op_type commit;
      logic   capture_tag;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

   // Multiply by x in the reflected GCM bit order.
   function automatic blk_type gf_shift(input blk_type v);
      blk_type r;
      r = v >> 1;
      if (v[0]) begin
         r[127:120] = r[127:120] ^ REDUCE_BYTE;
      end
      return r;
   endfunction

   // Keep the leading bytes of a block, zero the rest.
   function automatic blk_type pad_mask(input logic [4:0] n);
      blk_type m;
      for (int j = 0; j < 16; j++) begin
         m[127 - 8*j -: 8] = (5'(j) < n) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

endpackage

>>> src/masked_ghash_accumulator_top.sv
`timescale 1ns / 1ps
// Masked GHASH accumulator: GCM hashing with the running hash kept as two XOR
// shares. A start transaction makes two passes of the multiplier pair, an
// absorb transaction one pass; each pass runs the pair of 128-bit field
// multipliers, each scanning WINDOW_BITS bits of its operand per cycle. A
// finish transaction places the tag in an output register; while the tag
// waits, the next transaction is taken in any cycle in which the receiver
// does not stall, and every transaction is held while it does. Absorb with
// byte count zero and function code three are dropped. Configuration writes
// are always ready and must only be issued while the block is idle.
module masked_ghash_accumulator_top #(
   parameter int WINDOW_BITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_data_hi,
   input  logic [63:0] req_data_lo,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_tag_hi,
   output logic [63:0] rsp_tag_lo,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   mgha_pkg::cmd_type    cmd;
   mgha_pkg::status_type status;

   // Registers are plain flops: accept a write every cycle.
   assign csr_ready = 1'b1;

   // Sequence the multiplier passes and hold the response handshake.
   mgha_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_byte_count (req_byte_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   // Shares, correction terms, configuration and the windowed multipliers.
   mgha_dp #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_data_hi    (req_data_hi),
      .req_data_lo    (req_data_lo),
      .req_byte_count (req_byte_count),
      .rsp_tag_hi     (rsp_tag_hi),
      .rsp_tag_lo     (rsp_tag_lo)
   );

   // No transaction may enter while a multiplication is still running.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> status.done)
      else $error("transaction accepted while multiplier busy");

   // Results are only committed once the multiplier has finished.
   a_commit_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit != mgha_pkg::OP_NONE) |-> status.done)
      else $error("commit before multiplier finished");

   // A tag appears only after a finish transaction was taken.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall
                                 && req_func == mgha_pkg::FUNC_FINISH))
      else $error("response without finish transaction");

endmodule

>>> src/mgha_dp.sv
`timescale 1ns / 1ps
module mgha_dp #(
   parameter int WINDOW_BITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  mgha_pkg::cmd_type   cmd,
   output mgha_pkg::status_type status,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_data,
   input  logic [63:0]         req_data_hi,
   input  logic [63:0]         req_data_lo,
   input  logic [4:0]          req_byte_count,
   output logic [63:0]         rsp_tag_hi,
   output logic [63:0]         rsp_tag_lo
);

   localparam int unsigned STEPS = (128 + WINDOW_BITS - 1) / WINDOW_BITS;
   localparam int unsigned CNT_W = $clog2(STEPS + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(STEPS);

   logic [63:0] cfg_ff [mgha_pkg::NUM_REGS];
   mgha_pkg::blk_type h0, h1, s0, s1, x, t;
   mgha_pkg::blk_type sz_ff, so_ff, cz_ff, co_ff, cof_ff;
   mgha_pkg::blk_type za_ff, va_ff, aa_ff, zb_ff, vb_ff, ab_ff;
   mgha_pkg::blk_type za_in, va_in, aa_in, zb_in, vb_in, ab_in;
   mgha_pkg::blk_type tag_ff;
   logic first_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign h0 = {cfg_ff[mgha_pkg::REG_H0_HI], cfg_ff[mgha_pkg::REG_H0_LO]};
   assign h1 = {cfg_ff[mgha_pkg::REG_H1_HI], cfg_ff[mgha_pkg::REG_H1_LO]};
   assign s0 = {cfg_ff[mgha_pkg::REG_S0_HI], cfg_ff[mgha_pkg::REG_S0_LO]};
   assign s1 = {cfg_ff[mgha_pkg::REG_S1_HI], cfg_ff[mgha_pkg::REG_S1_LO]};
   assign x  = {req_data_hi, req_data_lo} & mgha_pkg::pad_mask(req_byte_count);
   assign t  = x ^ sz_ff ^ so_ff;

   assign status.done = (cnt_ff == CNT_END);
   assign rsp_tag_hi  = tag_ff[127:64];
   assign rsp_tag_lo  = tag_ff[63:0];

   // One window of both multipliers per cycle while the step count is not yet done.
   always_comb begin
      za_in = za_ff; va_in = va_ff; aa_in = aa_ff;
      zb_in = zb_ff; vb_in = vb_ff; ab_in = ab_ff;
      for (int k = 0; k < WINDOW_BITS; k++) begin
         za_in = za_in ^ (va_in & {128{aa_in[127]}});
         va_in = mgha_pkg::gf_shift(va_in);
         aa_in = aa_in << 1;
         zb_in = zb_in ^ (vb_in & {128{ab_in[127]}});
         vb_in = mgha_pkg::gf_shift(vb_in);
         ab_in = ab_in << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mgha_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
         sz_ff    <= '0;
         so_ff    <= '0;
         cz_ff    <= '0;
         co_ff    <= '0;
         cof_ff   <= '0;
         first_ff <= 1'b1;
         cnt_ff   <= CNT_END;
      end else begin
         if (csr_write) begin
            cfg_ff[csr_index] <= csr_data;
         end
         if (cmd.load != mgha_pkg::OP_NONE) begin
            cnt_ff <= '0;
         end else if (!status.done) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         case (cmd.commit)
            mgha_pkg::OP_CORR_A: begin
               cz_ff <= za_ff ^ s0;
               co_ff <= zb_ff;
            end
            mgha_pkg::OP_CORR_B: begin
               cof_ff   <= za_ff;
               first_ff <= 1'b1;
            end
            mgha_pkg::OP_BLOCK: begin
               sz_ff    <= za_ff ^ cz_ff;
               so_ff    <= zb_ff ^ (first_ff ? cof_ff : co_ff);
               first_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // Operand and accumulator registers; no reset needed.
   always_ff @(posedge clock) begin
      case (cmd.load)
         mgha_pkg::OP_CORR_A: begin
            aa_ff <= s0; va_ff <= h0; ab_ff <= s0; vb_ff <= h1;
            za_ff <= '0; zb_ff <= '0;
         end
         mgha_pkg::OP_CORR_B: begin
            aa_ff <= s1; va_ff <= h1; ab_ff <= s1; vb_ff <= h1;
            za_ff <= '0; zb_ff <= '0;
         end
         mgha_pkg::OP_BLOCK: begin
            aa_ff <= first_ff ? (x ^ s0) : t;
            ab_ff <= first_ff ? (x ^ s1) : t;
            va_ff <= h0; vb_ff <= h1;
            za_ff <= '0; zb_ff <= '0;
         end
         default: begin
            if (!status.done) begin
               za_ff <= za_in; va_ff <= va_in; aa_ff <= aa_in;
               zb_ff <= zb_in; vb_ff <= vb_in; ab_ff <= ab_in;
            end
         end
      endcase
      if (cmd.capture_tag) begin
         tag_ff <= sz_ff ^ so_ff ^ s1;
      end
   end

endmodule

>>> src/mgha_ctrl.sv
`timescale 1ns / 1ps
module mgha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [4:0]           req_byte_count,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mgha_pkg::status_type status,
   output mgha_pkg::cmd_type    cmd
);

   mgha_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = (state_ff != mgha_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mgha_pkg::ST_IDLE: begin
            if (accept && req_func == mgha_pkg::FUNC_START) begin
               state_in = mgha_pkg::ST_CORR_A;
            end else if (accept && req_func == mgha_pkg::FUNC_ABSORB
                         && req_byte_count != 5'd0) begin
               state_in = mgha_pkg::ST_BLOCK;
            end
         end
         mgha_pkg::ST_CORR_A: if (status.done) state_in = mgha_pkg::ST_CORR_B;
         mgha_pkg::ST_CORR_B: if (status.done) state_in = mgha_pkg::ST_IDLE;
         mgha_pkg::ST_BLOCK:  if (status.done) state_in = mgha_pkg::ST_IDLE;
         default: state_in = mgha_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load        = mgha_pkg::OP_NONE;
      cmd.commit      = mgha_pkg::OP_NONE;
      cmd.capture_tag = 1'b0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      case (state_ff)
         mgha_pkg::ST_IDLE: begin
            if (accept && req_func == mgha_pkg::FUNC_START) begin
               cmd.load = mgha_pkg::OP_CORR_A;
            end else if (accept && req_func == mgha_pkg::FUNC_ABSORB
                         && req_byte_count != 5'd0) begin
               cmd.load = mgha_pkg::OP_BLOCK;
            end else if (accept && req_func == mgha_pkg::FUNC_FINISH) begin
               cmd.capture_tag = 1'b1;
               rsp_valid_in    = 1'b1;
            end
         end
         mgha_pkg::ST_CORR_A: begin
            if (status.done) begin
               cmd.commit = mgha_pkg::OP_CORR_A;
               cmd.load   = mgha_pkg::OP_CORR_B;
            end
         end
         mgha_pkg::ST_CORR_B: if (status.done) cmd.commit = mgha_pkg::OP_CORR_B;
         mgha_pkg::ST_BLOCK:  if (status.done) cmd.commit = mgha_pkg::OP_BLOCK;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mgha_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> tb/sv/masked_ghash_accumulator_checker.sv
`timescale 1ns / 1ps
module masked_ghash_accumulator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_data_hi,
   input  logic [63:0] req_data_lo,
   input  logic [4:0]  req_byte_count,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_tag_hi,
   input  logic [63:0] rsp_tag_lo,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          tags_pending
);

   logic [127:0] key_zero, key_one, mask_zero, mask_one;
   logic [127:0] acc_zero, acc_one, fix_zero, fix_one, fix_one_first;
   logic         first_block;
   logic [127:0] tag_queue[$];

   // GCM field product, bit 127 holding the x^0 coefficient.
   function automatic logic [127:0] field_mul(input logic [127:0] a, input logic [127:0] b);
      logic [127:0] z;
      logic [127:0] v;
      z = '0;
      v = b;
      for (int i = 0; i < 128; i++) begin
         if (a[127 - i]) z = z ^ v;
         v = v[0] ? ((v >> 1) ^ {8'he1, 120'd0}) : (v >> 1);
      end
      return z;
   endfunction

   assign tags_pending = tag_queue.size();

   always @(posedge clock) begin
      logic [127:0] blk, mix, mask, got;
      int n;
      if (reset) begin
         key_zero <= '0; key_one <= '0; mask_zero <= '0; mask_one <= '0;
         acc_zero <= '0; acc_one <= '0; fix_zero <= '0; fix_one <= '0;
         fix_one_first <= '0; first_block <= 1'b1;
         fail_count <= 0;
         tag_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (mgha_pkg::reg_type'(csr_index))
               mgha_pkg::REG_H0_HI: key_zero[127:64]  <= csr_data;
               mgha_pkg::REG_H0_LO: key_zero[63:0]    <= csr_data;
               mgha_pkg::REG_H1_HI: key_one[127:64]   <= csr_data;
               mgha_pkg::REG_H1_LO: key_one[63:0]     <= csr_data;
               mgha_pkg::REG_S0_HI: mask_zero[127:64] <= csr_data;
               mgha_pkg::REG_S0_LO: mask_zero[63:0]   <= csr_data;
               mgha_pkg::REG_S1_HI: mask_one[127:64]  <= csr_data;
               mgha_pkg::REG_S1_LO: mask_one[63:0]    <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (mgha_pkg::func_type'(req_func))
               mgha_pkg::FUNC_START: begin
                  fix_zero      <= field_mul(mask_zero, key_zero) ^ mask_zero;
                  fix_one       <= field_mul(mask_zero, key_one);
                  fix_one_first <= field_mul(mask_one, key_one);
                  first_block   <= 1'b1;
               end
               mgha_pkg::FUNC_ABSORB: begin
                  n = (req_byte_count > 16) ? 16 : req_byte_count;
                  if (n != 0) begin
                     mask = '0;
                     for (int j = 0; j < n; j++) mask[127 - 8*j -: 8] = 8'hff;
                     blk = {req_data_hi, req_data_lo} & mask;
                     if (first_block) begin
                        acc_zero <= field_mul(blk ^ mask_zero, key_zero) ^ fix_zero;
                        acc_one  <= field_mul(blk ^ mask_one, key_one) ^ fix_one_first;
                     end else begin
                        mix = blk ^ acc_zero ^ acc_one;
                        acc_zero <= field_mul(mix, key_zero) ^ fix_zero;
                        acc_one  <= field_mul(mix, key_one) ^ fix_one;
                     end
                     first_block <= 1'b0;
                  end
               end
               mgha_pkg::FUNC_FINISH: tag_queue.push_back(acc_zero ^ acc_one ^ mask_one);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_tag_hi, rsp_tag_lo};
            if (tag_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected tag %h", got);
               fail_count <= fail_count + 1;
            end else begin
               if (got !== tag_queue[0]) begin
                  if (fail_count < 10)
                     $display("tag mismatch: expected %h actual %h", tag_queue[0], got);
                  fail_count <= fail_count + 1;
               end
               void'(tag_queue.pop_front());
            end
         end
      end
   end

endmodule

>>> tb/sv/masked_ghash_accumulator_top_tb.sv
`timescale 1ns / 1ps
module masked_ghash_accumulator_top_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = mgha_pkg::FUNC_START;
   logic [63:0] req_data_hi = '0;
   logic [63:0] req_data_lo = '0;
   logic [4:0]  req_byte_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_tag_hi, rsp_tag_lo;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = mgha_pkg::REG_H0_HI;
   logic [63:0] csr_data = '0;
   int          fail_count, tags_pending;
   int          cycle_count = 0;
   // idle rates, percent
   int          send_idle = 0, recv_idle = 0;

   localparam int CYCLE_LIMIT = 600000;

   masked_ghash_accumulator_top u_top (.*);
   masked_ghash_accumulator_checker u_chk (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver: stall at random at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // Watchdog: abandon a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(7))
         0: w = '0;
         1: w = '1;
         default: ;
      endcase
      return w;
   endfunction

   // Write one register; the port is always ready but wait on the handshake.
   // Valid stays up so that writes can follow back to back.
   task automatic write_reg(input mgha_pkg::reg_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Hold one transaction until it is accepted, idling beforehand at random.
   // Valid stays up after acceptance; the next send or settle drops it.
   task automatic send(input mgha_pkg::func_type f, input logic [63:0] hi,
                       input logic [63:0] lo, input logic [4:0] n);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_data_hi    <= hi;
      req_data_lo    <= lo;
      req_byte_count <= n;
      do @(posedge clock); while (req_stall);
   endtask

   // Drain: wait for outstanding tags, then let the longest operation finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (tags_pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic load_keys(input int style);
      for (int r = 0; r < mgha_pkg::NUM_REGS; r++) begin
         case (style)
            0: write_reg(mgha_pkg::reg_type'(r), '0);
            1: write_reg(mgha_pkg::reg_type'(r), '1);
            default: write_reg(mgha_pkg::reg_type'(r), rand_word());
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_message();
      int blocks;
      blocks = $urandom_range(6);
      if ($urandom_range(9) != 0)
         send(mgha_pkg::FUNC_START, rand_word(), rand_word(), 5'($urandom));
      for (int b = 0; b < blocks; b++) begin
         // mostly proper counts, some zero or oversized
         if ($urandom_range(9) == 0)
            send(mgha_pkg::FUNC_ABSORB, rand_word(), rand_word(), 5'($urandom));
         else
            send(mgha_pkg::FUNC_ABSORB, rand_word(), rand_word(),
                 5'($urandom_range(16, 1)));
      end
      if ($urandom_range(19) == 0)
         send(mgha_pkg::FUNC_NONE, rand_word(), rand_word(), 5'($urandom));
      send(mgha_pkg::FUNC_FINISH, rand_word(), rand_word(), 5'($urandom));
      if ($urandom_range(4) == 0) send(mgha_pkg::FUNC_FINISH, '0, '0, 5'd0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero keys, then all-ones keys, random keys and zero keys again.
      send(mgha_pkg::FUNC_FINISH, '0, '0, 5'd0);
      send(mgha_pkg::FUNC_ABSORB, '1, '1, 5'd16);
      settle();
      load_keys(1);
      send(mgha_pkg::FUNC_START, '0, '0, 5'd0);
      send(mgha_pkg::FUNC_ABSORB, '1, '1, 5'd1);
      send(mgha_pkg::FUNC_ABSORB, '1, '1, 5'd0);
      send(mgha_pkg::FUNC_ABSORB, '1, '1, 5'd8);
      send(mgha_pkg::FUNC_ABSORB, '1, '1, 5'd9);
      send(mgha_pkg::FUNC_ABSORB, '1, '1, 5'd31);
      send(mgha_pkg::FUNC_FINISH, '0, '0, 5'd0);
      send(mgha_pkg::FUNC_ABSORB, '0, '0, 5'd16);
      send(mgha_pkg::FUNC_NONE, '1, '1, 5'd16);
      send(mgha_pkg::FUNC_FINISH, '1, '1, 5'd31);
      send(mgha_pkg::FUNC_FINISH, '0, '0, 5'd0);
      settle();
      load_keys(2);
      send(mgha_pkg::FUNC_START, '0, '0, 5'd0);
      send(mgha_pkg::FUNC_ABSORB, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15);
      send(mgha_pkg::FUNC_ABSORB, 64'h8000000000000000, 64'h1, 5'd17);
      send(mgha_pkg::FUNC_START, '0, '0, 5'd0);
      send(mgha_pkg::FUNC_START, '0, '0, 5'd0);
      send(mgha_pkg::FUNC_ABSORB, '1, '0, 5'd16);
      send(mgha_pkg::FUNC_FINISH, '0, '0, 5'd0);
      settle();
      load_keys(0);
      send(mgha_pkg::FUNC_START, '0, '0, 5'd0);
      send(mgha_pkg::FUNC_ABSORB, '1, '1, 5'd16);
      send(mgha_pkg::FUNC_FINISH, '0, '0, 5'd0);
      settle();

      // Random phases, each with fresh keys and its own idle pattern.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 19 : (phase == 1) ? 60 : 0;
         recv_idle = (phase == 0) ? 60 : (phase == 1) ? 19 : 0;
         for (int k = 0; k < 4; k++) begin
            load_keys((k == 3) ? phase % 2 : 2);
            for (int m = 0; m < 12; m++) random_message();
            settle();
         end
      end

      recv_idle = 0;
      settle();
      if (fail_count == 0 && tags_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
